// ----- hw/rtl/ray_closest_approach_top_assert.svh -----
// ----------------------------------------------------------------------------
// Ray closest approach assertion macros
// Shared property forms for the closest approach pipeline checks.
// ----------------------------------------------------------------------------
`ifndef RAY_CLOSEST_APPROACH_TOP_ASSERT_SVH
`define RAY_CLOSEST_APPROACH_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rca check failed");

// The consequent must hold in the cycle after the antecedent.
`define RCA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rca check failed");

`endif

// ----- hw/rtl/rca_pkg.sv -----
// ----------------------------------------------------------------------------
// Ray closest approach package
// Shared widths, constants and types of the closest approach pipeline.
// ----------------------------------------------------------------------------
package rca_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int IN_W       = 304;
  localparam int OUT_W      = 96;
  localparam int LIMIT_W    = 17;
  localparam int DVD_W      = 58;
  localparam int DSR_W      = 17;
  localparam int BITS_PER_ST = 2;
  localparam int DIV_STAGES = DVD_W / BITS_PER_ST;

  typedef struct packed {
    logic par;
    logic neg;
  } rca_side_t;

endpackage

// ----- hw/rtl/rca_front.sv -----
// ----------------------------------------------------------------------------
// Ray closest approach front end
// Origin offset, dot products, rounding, denominator and numerators in seven
// register stages.
// ----------------------------------------------------------------------------
module rca_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [rca_pkg::IN_W-1:0]       in_data,
  input  logic [rca_pkg::LIMIT_W-1:0]    limit,
  output logic                           out_valid,
  output logic [rca_pkg::DVD_W-1:0]      dvd_a,
  output logic [rca_pkg::DVD_W-1:0]      dvd_b,
  output logic [rca_pkg::DSR_W-1:0]      dsr,
  output rca_pkg::rca_side_t             side_a,
  output rca_pkg::rca_side_t             side_b
);

  logic [6:0] v_r;

  logic signed [31:0] oa [3];
  logic signed [31:0] ob [3];
  logic signed [17:0] da [3];
  logic signed [17:0] db [3];

  logic signed [32:0] p_r [3];
  logic signed [17:0] da_r [3];
  logic signed [17:0] db_r [3];

  logic signed [35:0] m_uu_r [3];
  logic signed [50:0] m_s1_r [3];
  logic signed [50:0] m_s2_r [3];

  logic signed [37:0] uu_r;
  logic signed [52:0] s1_r;
  logic signed [52:0] s2_r;

  logic signed [38:0] uu_t;
  logic signed [53:0] s1_t;
  logic signed [53:0] s2_t;
  logic signed [22:0] u_w;
  logic signed [18:0] u_nxt;
  logic signed [37:0] q1_nxt;
  logic signed [37:0] q2_nxt;
  logic signed [18:0] u4_r;
  logic signed [37:0] q1_4_r;
  logic signed [37:0] q2_4_r;

  logic signed [37:0] uu2_r;
  logic signed [18:0] u5_r;
  logic signed [37:0] q1_5_r;
  logic signed [37:0] q2_5_r;

  logic signed [38:0] uu2_t;
  logic signed [22:0] den_w;
  logic signed [56:0] uq1_r;
  logic signed [56:0] uq2_r;
  logic signed [37:0] q1_6_r;
  logic signed [37:0] q2_6_r;
  logic [rca_pkg::DSR_W-1:0] den_r;
  logic par_r;

  logic signed [57:0] na;
  logic signed [57:0] nb;
  logic [57:0] mag_a;
  logic [57:0] mag_b;
  logic [rca_pkg::DVD_W-1:0] dvd_a_r;
  logic [rca_pkg::DVD_W-1:0] dvd_b_r;
  logic [rca_pkg::DSR_W-1:0] dsr_r;
  rca_pkg::rca_side_t side_a_r;
  rca_pkg::rca_side_t side_b_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      oa[i] = in_data[32*i +: 32];
      da[i] = in_data[96 + 18*i +: 18];
      ob[i] = in_data[150 + 32*i +: 32];
      db[i] = in_data[246 + 18*i +: 18];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_r[i]    <= {ob[i][31], ob[i]} - {oa[i][31], oa[i]};
        da_r[i]   <= da[i];
        db_r[i]   <= db[i];
        m_uu_r[i] <= da_r[i] * db_r[i];
        m_s1_r[i] <= da_r[i] * p_r[i];
        m_s2_r[i] <= db_r[i] * p_r[i];
      end
      uu_r <= 38'(m_uu_r[0]) + 38'(m_uu_r[1]) + 38'(m_uu_r[2]);
      s1_r <= 53'(m_s1_r[0]) + 53'(m_s1_r[1]) + 53'(m_s1_r[2]);
      s2_r <= 53'(m_s2_r[0]) + 53'(m_s2_r[1]) + 53'(m_s2_r[2]);
    end
  end

  always_comb begin
    uu_t = 39'(uu_r) + 39'sd32768;
    s1_t = 54'(s1_r) + 54'sd32768;
    s2_t = 54'(s2_r) + 54'sd32768;
    u_w  = uu_t[38:rca_pkg::FRAC_BITS];
    if (u_w > 23'sd131072) begin
      u_nxt = 19'sd131072;
    end else if (u_w < -23'sd131072) begin
      u_nxt = -19'sd131072;
    end else begin
      u_nxt = u_w[18:0];
    end
    q1_nxt = s1_t[53:rca_pkg::FRAC_BITS];
    q2_nxt = -s2_t[53:rca_pkg::FRAC_BITS];
  end

  always_comb begin
    uu2_t = 39'(uu2_r) + 39'sd32768;
    den_w = 23'sd65536 - uu2_t[38:rca_pkg::FRAC_BITS];
  end

  always_comb begin
    na    = (58'(q1_6_r) <<< rca_pkg::FRAC_BITS) + 58'(uq2_r);
    nb    = 58'(uq1_r) + (58'(q2_6_r) <<< rca_pkg::FRAC_BITS);
    mag_a = na[57] ? 58'(-na) : 58'(na);
    mag_b = nb[57] ? 58'(-nb) : 58'(nb);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u4_r   <= u_nxt;
      q1_4_r <= q1_nxt;
      q2_4_r <= q2_nxt;
      uu2_r  <= u4_r * u4_r;
      u5_r   <= u4_r;
      q1_5_r <= q1_4_r;
      q2_5_r <= q2_4_r;
      uq1_r  <= u5_r * q1_5_r;
      uq2_r  <= u5_r * q2_5_r;
      q1_6_r <= q1_5_r;
      q2_6_r <= q2_5_r;
      den_r  <= den_w[16:0];
      par_r  <= (den_w <= $signed({6'b0, limit}));
      dvd_a_r <= mag_a + 58'(den_r >> 1);
      dvd_b_r <= mag_b + 58'(den_r >> 1);
      dsr_r   <= par_r ? 17'd1 : den_r;
      side_a_r <= '{par: par_r, neg: na[57]};
      side_b_r <= '{par: par_r, neg: nb[57]};
    end
  end

  assign out_valid = v_r[6];
  assign dvd_a     = dvd_a_r;
  assign dvd_b     = dvd_b_r;
  assign dsr       = dsr_r;
  assign side_a    = side_a_r;
  assign side_b    = side_b_r;

endmodule

// ----- hw/rtl/rca_div.sv -----
// ----------------------------------------------------------------------------
// Ray closest approach divider
// Pipelined restoring divider, two quotient bits per register stage.
// ----------------------------------------------------------------------------
module rca_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [rca_pkg::DVD_W-1:0]  dvd,
  input  logic [rca_pkg::DSR_W-1:0]  dsr,
  input  rca_pkg::rca_side_t         side_in,
  output logic                       out_valid,
  output logic [rca_pkg::DVD_W-1:0]  quo,
  output rca_pkg::rca_side_t         side_out
);

  localparam int NST = rca_pkg::DIV_STAGES;

  logic [NST-1:0]               v_r;
  logic [rca_pkg::DSR_W-1:0]    rem_r  [NST];
  logic [rca_pkg::DVD_W-1:0]    dvd_r  [NST];
  logic [rca_pkg::DVD_W-1:0]    quo_r  [NST];
  logic [rca_pkg::DSR_W-1:0]    dsr_r  [NST];
  rca_pkg::rca_side_t           side_r [NST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic [rca_pkg::DSR_W-1:0] rem_i;
    logic [rca_pkg::DVD_W-1:0] dvd_i;
    logic [rca_pkg::DVD_W-1:0] quo_i;
    logic [rca_pkg::DSR_W-1:0] dsr_i;
    rca_pkg::rca_side_t        side_i;
    logic [rca_pkg::DSR_W-1:0] rem_o;
    logic [rca_pkg::DVD_W-1:0] dvd_o;
    logic [rca_pkg::DVD_W-1:0] quo_o;

    if (s == 0) begin : g_head
      assign rem_i  = '0;
      assign dvd_i  = dvd;
      assign quo_i  = '0;
      assign dsr_i  = dsr;
      assign side_i = side_in;
    end else begin : g_body
      assign rem_i  = rem_r[s-1];
      assign dvd_i  = dvd_r[s-1];
      assign quo_i  = quo_r[s-1];
      assign dsr_i  = dsr_r[s-1];
      assign side_i = side_r[s-1];
    end

    always_comb begin
      logic [rca_pkg::DSR_W:0] trial;
      rem_o = rem_i;
      dvd_o = dvd_i;
      quo_o = quo_i;
      for (int k = 0; k < rca_pkg::BITS_PER_ST; k++) begin
        trial = {rem_o, dvd_o[rca_pkg::DVD_W-1]};
        dvd_o = dvd_o << 1;
        if (trial >= {1'b0, dsr_i}) begin
          rem_o = 17'(trial - {1'b0, dsr_i});
          quo_o = {quo_o[rca_pkg::DVD_W-2:0], 1'b1};
        end else begin
          rem_o = trial[rca_pkg::DSR_W-1:0];
          quo_o = {quo_o[rca_pkg::DVD_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_o;
        dvd_r[s]  <= dvd_o;
        quo_r[s]  <= quo_o;
        dsr_r[s]  <= dsr_i;
        side_r[s] <= side_i;
      end
    end
  end

  assign out_valid = v_r[NST-1];
  assign quo       = quo_r[NST-1];
  assign side_out  = side_r[NST-1];

endmodule

// ----- hw/rtl/ray_closest_approach_top.sv -----
// Throughput: one request per cycle while the output is not stalled; the 29-stage divider pipeline sets depth.
// A stalled output holds the whole pipeline; in_tready follows that stall.
// Reset: synchronous, active low; clears valid bits and loads the limit with 7.
// ----------------------------------------------------------------------------
// Ray closest approach top level
// Closest-point parameters of two 3D rays in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
`include "ray_closest_approach_top_assert.svh"

module ray_closest_approach_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [rca_pkg::LIMIT_W-1:0]  cfg_wdata,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // a_origin_x, a_origin_y, a_origin_z, a_dir_x, a_dir_y, a_dir_z,
  // b_origin_x, b_origin_y, b_origin_z, b_dir_x, b_dir_y, b_dir_z, zero pad
  input  logic [rca_pkg::IN_W-1:0]     in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // param_a, param_b
  output logic [rca_pkg::OUT_W-1:0]    out_tdata,
  // near_parallel
  output logic                         out_tuser
);

  logic                          en;
  logic [rca_pkg::LIMIT_W-1:0]   limit_r;
  logic                          f_valid;
  logic [rca_pkg::DVD_W-1:0]     dvd_a;
  logic [rca_pkg::DVD_W-1:0]     dvd_b;
  logic [rca_pkg::DSR_W-1:0]     dsr;
  rca_pkg::rca_side_t            side_a;
  rca_pkg::rca_side_t            side_b;
  logic                          va;
  logic                          vb;
  logic [rca_pkg::DVD_W-1:0]     qa;
  logic [rca_pkg::DVD_W-1:0]     qb;
  rca_pkg::rca_side_t            sa;
  rca_pkg::rca_side_t            sb;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [rca_pkg::OUT_W-1:0]     out_data_r;
  logic                          out_par_r;
  logic [47:0]                   pa;
  logic [47:0]                   pb;

  function automatic logic [47:0] sat_q(input logic [rca_pkg::DVD_W-1:0] q,
                                        input rca_pkg::rca_side_t sd);
    logic [47:0] r;
    if (sd.par) begin
      r = '0;
    end else if (sd.neg) begin
      r = (q > 58'h800000000000) ? 48'h800000000000 : 48'(-q);
    end else begin
      r = (q > 58'h7FFFFFFFFFFF) ? 48'h7FFFFFFFFFFF : q[47:0];
    end
    return r;
  endfunction

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 17'd7;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  rca_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_data   (in_tdata),
    .limit     (limit_r),
    .out_valid (f_valid),
    .dvd_a     (dvd_a),
    .dvd_b     (dvd_b),
    .dsr       (dsr),
    .side_a    (side_a),
    .side_b    (side_b)
  );

  rca_div u_div_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .dvd       (dvd_a),
    .dsr       (dsr),
    .side_in   (side_a),
    .out_valid (va),
    .quo       (qa),
    .side_out  (sa)
  );

  rca_div u_div_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .dvd       (dvd_b),
    .dsr       (dsr),
    .side_in   (side_b),
    .out_valid (vb),
    .quo       (qb),
    .side_out  (sb)
  );

  assign pa            = sat_q(qa, sa);
  assign pb            = sat_q(qb, sb);
  assign out_valid_nxt = en ? va : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {pb, pa};
      out_par_r  <= sa.par;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_par_r;

  `RCA_ASSERT_SAME(a_div_lockstep, va || vb, va && vb && (sa.par == sb.par))
  `RCA_ASSERT_SAME(a_par_zero, out_valid_r && out_tuser, out_tdata == '0)
  `RCA_ASSERT_NEXT(a_hold_result, out_valid_r && !out_tready,
                   out_valid_r && $stable(out_tdata))

endmodule
